// File: rtl/md4_pkg.sv
// Shared constants, command/status types and lookup functions for the MD4 digest block.
package md4_pkg;

   // Initial chaining words
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   // Additive constants of rounds two and three
   localparam logic [31:0] K_ROUND2 = 32'h5A827999;
   localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

   // Padding and block positions
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] BLOCK_LAST = 6'h3f;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] STEP_LAST  = 6'd47;

   // Byte source codes for the block buffer write
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic       absorb;     // write one byte into the block buffer, count it
      logic [1:0] src;        // byte source
      logic       latch_len;  // capture message bit length
      logic       load_work;  // copy chaining value into working words
      logic       step_en;    // run one compression step
      logic [5:0] step_idx;   // step being run
      logic [5:0] rd_idx;     // step whose message word is read now
      logic       fold;       // add working words into chaining value
      logic       emit;       // load digest register, reinitialize
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [5:0] count_lo;   // byte position inside the current block
   } status_type;

   // Message word used by each step
   function automatic logic [3:0] word_index(input logic [5:0] step);
      logic [3:0] idx;
      idx = 4'd0;
      case (step[5:4])
         2'd0: idx = step[3:0];
         2'd1: idx = {step[1:0], step[3:2]};
         2'd2: idx = {step[0], step[1], step[2], step[3]};
         default: idx = 4'd0;
      endcase
      return idx;
   endfunction

   // Left rotate amount of each step
   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [4:0] s;
      s = 5'd3;
      case ({step[5:4], step[1:0]})
         4'b00_00: s = 5'd3;
         4'b00_01: s = 5'd7;
         4'b00_10: s = 5'd11;
         4'b00_11: s = 5'd19;
         4'b01_00: s = 5'd3;
         4'b01_01: s = 5'd5;
         4'b01_10: s = 5'd9;
         4'b01_11: s = 5'd13;
         4'b10_00: s = 5'd3;
         4'b10_01: s = 5'd9;
         4'b10_10: s = 5'd11;
         4'b10_11: s = 5'd15;
         default:  s = 5'd3;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/md4_message_digest.sv
// MD4 digest block, top level: valid/stall byte input, 128-bit digest output.
// A byte item is taken while not stalled; the 64th byte of a block starts a compression
// that stalls input (one word read, 48 steps of the shared step unit, one add). At the
// end of message: pad, zero and eight length bytes, one or two compressions, then the
// digest loads into the output register; the next item is taken once that is done.
// Synchronous active-high reset restores the initial chaining value and a zero byte count.
module md4_message_digest import md4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_low,
   output logic [63:0] rsp_digest_high
);

   cmd_type    cmd;
   status_type status;

   md4_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .status             (status)
   );

   md4_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_low  (rsp_digest_low),
      .rsp_digest_high (rsp_digest_high)
   );

endmodule

// File: rtl/md4_ctrl.sv
// Controller state machine: byte intake, padding sequence, compression steps, digest emit.
module md4_ctrl import md4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_byte_present,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PAD80    = 3'd1;
   localparam logic [2:0] ST_PADZ     = 3'd2;
   localparam logic [2:0] ST_LENB     = 3'd3;
   localparam logic [2:0] ST_CMP_RD   = 3'd4;
   localparam logic [2:0] ST_CMP_STEP = 3'd5;
   localparam logic [2:0] ST_CMP_ADD  = 3'd6;
   localparam logic [2:0] ST_EMIT     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [5:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       block_full;
   logic       out_free;

   assign block_full = (status.count_lo == BLOCK_LAST);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.src      = SRC_DATA;
      cmd.step_idx = step_ff;
      cmd.rd_idx   = step_ff + 6'd1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.absorb = req_byte_present;
               if (req_byte_present && block_full) begin
                  ret_in   = req_end_of_message ? ST_PAD80 : ST_IDLE;
                  state_in = ST_CMP_RD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            cmd.absorb    = 1'b1;
            cmd.src       = SRC_PAD;
            cmd.latch_len = 1'b1;
            ret_in        = ST_PADZ;
            state_in      = block_full ? ST_CMP_RD : ST_PADZ;
         end
         ST_PADZ: begin
            if (status.count_lo == LEN_POS) begin
               state_in = ST_LENB;
            end else begin
               cmd.absorb = 1'b1;
               cmd.src    = SRC_ZERO;
               ret_in     = ST_PADZ;
               if (block_full) begin
                  state_in = ST_CMP_RD;
               end
            end
         end
         ST_LENB: begin
            cmd.absorb = 1'b1;
            cmd.src    = SRC_LEN;
            ret_in     = ST_EMIT;
            if (block_full) begin
               state_in = ST_CMP_RD;
            end
         end
         ST_CMP_RD: begin
            cmd.load_work = 1'b1;
            cmd.rd_idx    = 6'd0;
            step_in       = 6'd0;
            state_in      = ST_CMP_STEP;
         end
         ST_CMP_STEP: begin
            cmd.step_en = 1'b1;
            step_in     = step_ff + 6'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_CMP_ADD;
            end
         end
         ST_CMP_ADD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         step_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/md4_dp.sv
// Datapath: block buffer memory, byte count, bit length, chaining value, step unit, digest.
module md4_dp import md4_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_data_byte,
   input  cmd_type      cmd,
   output status_type   status,
   output logic [63:0]  rsp_digest_low,
   output logic [63:0]  rsp_digest_high
);

   logic [31:0] buf_mem_ff [16];
   logic [31:0] word_ff;
   logic [60:0] count_ff, count_in;
   logic [63:0] len_ff;
   logic [31:0] cv_ff [4];
   logic [31:0] cv_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [63:0] dig_lo_ff, dig_hi_ff;
   logic [7:0]  wr_byte;
   logic [31:0] f_val, k_val, sum, rot;
   logic [63:0] rot_wide;
   logic [4:0]  rot_s;

   assign status.count_lo = count_ff[5:0];
   assign rsp_digest_low  = dig_lo_ff;
   assign rsp_digest_high = dig_hi_ff;

   // Byte source select
   always_comb begin
      case (cmd.src)
         SRC_DATA: wr_byte = req_data_byte;
         SRC_PAD:  wr_byte = PAD_BYTE;
         SRC_ZERO: wr_byte = 8'h00;
         SRC_LEN:  wr_byte = len_ff[8*count_ff[2:0] +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   // Block buffer: byte lane writes, registered word read
   always_ff @(posedge clock) begin
      if (cmd.absorb) begin
         buf_mem_ff[count_ff[5:2]][8*count_ff[1:0] +: 8] <= wr_byte;
      end
      word_ff <= buf_mem_ff[word_index(cmd.rd_idx)];
   end

   // Bit length, captured before the pad byte
   always_ff @(posedge clock) begin
      if (cmd.latch_len) begin
         len_ff <= {count_ff, 3'b000};
      end
   end

   // One compression step
   always_comb begin
      case (cmd.step_idx[5:4])
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = 32'h0;
         end
         2'd1: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_ROUND2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_ROUND3;
         end
      endcase
      sum      = a_ff + f_val + word_ff + k_val;
      rot_s    = rot_amount(cmd.step_idx);
      rot_wide = {sum, sum} << rot_s;
      rot      = rot_wide[63:32];
   end

   // Working words
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.load_work) begin
         a_in = cv_ff[0];
         b_in = cv_ff[1];
         c_in = cv_ff[2];
         d_in = cv_ff[3];
      end else if (cmd.step_en) begin
         a_in = d_ff;
         b_in = rot;
         c_in = b_ff;
         d_in = c_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   // Chaining value and byte count
   always_comb begin
      cv_in[0] = cv_ff[0];
      cv_in[1] = cv_ff[1];
      cv_in[2] = cv_ff[2];
      cv_in[3] = cv_ff[3];
      count_in = count_ff;
      if (cmd.emit) begin
         cv_in[0] = IV_A;
         cv_in[1] = IV_B;
         cv_in[2] = IV_C;
         cv_in[3] = IV_D;
         count_in = '0;
      end else begin
         if (cmd.fold) begin
            cv_in[0] = cv_ff[0] + a_ff;
            cv_in[1] = cv_ff[1] + b_ff;
            cv_in[2] = cv_ff[2] + c_ff;
            cv_in[3] = cv_ff[3] + d_ff;
         end
         if (cmd.absorb) begin
            count_in = count_ff + 61'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= IV_A;
         cv_ff[1] <= IV_B;
         cv_ff[2] <= IV_C;
         cv_ff[3] <= IV_D;
         count_ff <= '0;
      end else begin
         cv_ff    <= cv_in;
         count_ff <= count_in;
      end
   end

   // Digest output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         dig_lo_ff <= {cv_ff[1], cv_ff[0]};
         dig_hi_ff <= {cv_ff[3], cv_ff[2]};
      end
   end

endmodule

// File: rtl/md4_checker.sv
// Port-level checker for the MD4 digest block, bound to the top level.
module md4_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_end_of_message,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_digest_low,
   input logic [63:0] rsp_digest_high
);

   // A stalled digest stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("digest dropped while stalled");

   // A stalled digest holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_digest_low) && $stable(rsp_digest_high))
      else $error("digest changed while stalled");

   // After an end item the block is busy padding
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_message |=> req_stall)
      else $error("input taken right after end of message");

   // A new digest only appears out of the finishing sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("digest appeared while taking input");

endmodule

bind md4_message_digest md4_checker u_md4_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_end_of_message (req_end_of_message),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_digest_low     (rsp_digest_low),
   .rsp_digest_high    (rsp_digest_high)
);
